/* src/ramp_crossing_sweep_tracker_unit_defines.svh */
// Assertion macros used by the block's datapath.
`ifndef RAMP_CROSSING_SWEEP_TRACKER_UNIT_DEFINES_SVH
`define RAMP_CROSSING_SWEEP_TRACKER_UNIT_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define RCST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define RCST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/rcst_pkg.sv */
`timescale 1ns / 1ps
package rcst_pkg;

	localparam int MAX_HITS = 8;
	localparam int HIT_CNT_W = $clog2(MAX_HITS + 1);

	localparam logic [15:0] LOOKAHEAD_RST = 16'd2304;
	localparam logic signed [31:0] ORIGIN_RST = -32'sd256;
	localparam logic signed [31:0] SCAN_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {
		KIND_SCAN  = 2'd0,
		KIND_HIT   = 2'd1,
		KIND_SWEEP = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLAGS,
		ST_OUT_SCAN,
		ST_OUT_HIT,
		ST_OUT_SWEEP
	} state_t;

	typedef struct packed {
		logic  load_in;
		logic  calc_scan;
		logic  calc_flags;
		logic  emit;
		kind_t sel;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic has_hits;
		logic last_hit;
		logic has_sweep;
	} stat_t;

endpackage

/* src/rcst_controller.sv */
`timescale 1ns / 1ps
module rcst_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rcst_pkg::stat_t stat,
	output rcst_pkg::cmd_t  cmd
);
	import rcst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: state_d = ST_FLAGS;
			ST_FLAGS: state_d = ST_OUT_SCAN;
			ST_OUT_SCAN: begin
				if (stat.out_free) begin
					if (stat.has_hits) state_d = ST_OUT_HIT;
					else if (stat.has_sweep) state_d = ST_OUT_SWEEP;
					else state_d = ST_IDLE;
				end
			end
			ST_OUT_HIT: begin
				if (stat.out_free && stat.last_hit) begin
					state_d = stat.has_sweep ? ST_OUT_SWEEP : ST_IDLE;
				end
			end
			ST_OUT_SWEEP: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd.load_in    = 1'b0;
		cmd.calc_scan  = 1'b0;
		cmd.calc_flags = 1'b0;
		cmd.emit       = 1'b0;
		cmd.sel        = KIND_SCAN;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_SCAN: cmd.calc_scan = 1'b1;
			ST_FLAGS: cmd.calc_flags = 1'b1;
			ST_OUT_SCAN: begin
				cmd.emit = stat.out_free;
				cmd.sel  = KIND_SCAN;
			end
			ST_OUT_HIT: begin
				cmd.emit = stat.out_free;
				cmd.sel  = KIND_HIT;
			end
			ST_OUT_SWEEP: begin
				cmd.emit = stat.out_free;
				cmd.sel  = KIND_SWEEP;
			end
			default: ;
		endcase
	end

endmodule

/* src/rcst_datapath.sv */
`timescale 1ns / 1ps
`include "ramp_crossing_sweep_tracker_unit_defines.svh"
module rcst_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic signed [31:0]  ramp_ms,
	input  logic                end_of_block,
	input  rcst_pkg::cmd_t      cmd,
	output rcst_pkg::stat_t     stat,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [1:0]          kind,
	output logic signed [31:0]  scan_position,
	output logic signed [23:0]  crossed_ms,
	output logic signed [31:0]  sweep_start,
	output logic signed [31:0]  sweep_end,
	output logic                hits_truncated,
	output logic                last
);
	import rcst_pkg::*;

	logic [15:0]          lookahead_q;
	logic signed [31:0]   ramp_q;
	logic                 eob_q;
	logic signed [31:0]   scan_q;
	logic signed [31:0]   prev_ramp_q;
	logic                 prev_ramp_valid_q;
	logic signed [31:0]   prev_scan_q;
	logic                 prev_scan_valid_q;
	logic signed [31:0]   origin_q;
	logic [HIT_CNT_W-1:0] hit_cnt_q;
	logic signed [23:0]   cur_ms_q;
	logic                 trunc_q;
	logic                 has_sweep_q;
	logic signed [31:0]   sw_start_q;
	logic signed [31:0]   sw_end_q;

	logic                 out_valid_q;
	kind_t                kind_q;
	logic signed [31:0]   scan_out_q;
	logic signed [23:0]   crossed_q;
	logic signed [31:0]   start_out_q;
	logic signed [31:0]   end_out_q;
	logic                 trunc_out_q;
	logic                 last_q;

	logic [32:0]          scan_sum;
	logic                 scan_sat;
	logic                 rose;
	logic signed [24:0]   ms_diff;
	logic                 too_many;
	logic                 wrap;
	logic                 eob_sweep;
	logic                 out_free;
	logic signed [23:0]   next_ms;

	assign scan_sum = {ramp_q[31], ramp_q} + {17'd0, lookahead_q};
	assign scan_sat = !scan_sum[32] && scan_sum[31];
	assign rose     = prev_ramp_valid_q && (ramp_q > prev_ramp_q);
	assign ms_diff  = $signed({ramp_q[31], ramp_q[31:8]})
		- $signed({prev_ramp_q[31], prev_ramp_q[31:8]});
	assign too_many = ms_diff > $signed(25'(MAX_HITS));
	assign wrap      = prev_scan_valid_q && (scan_q < prev_scan_q);
	assign eob_sweep = eob_q && !wrap && (origin_q < scan_q);
	assign out_free  = !out_valid_q || out_ready;
	assign next_ms   = cur_ms_q + 24'sd1;

	assign stat.out_free  = out_free;
	assign stat.has_hits  = hit_cnt_q != '0;
	assign stat.last_hit  = hit_cnt_q == HIT_CNT_W'(1);
	assign stat.has_sweep = has_sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookahead_q <= LOOKAHEAD_RST;
		end else if (cfg_we) begin
			lookahead_q <= cfg_wdata;
		end
	end

	// capture item and per-item work values
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ramp_q <= ramp_ms;
			eob_q  <= end_of_block;
		end
		if (cmd.calc_scan) begin
			scan_q   <= scan_sat ? SCAN_MAX : $signed(scan_sum[31:0]);
			cur_ms_q <= prev_ramp_q[31:8];
			trunc_q  <= rose && too_many;
		end else if (cmd.emit && cmd.sel == KIND_HIT) begin
			cur_ms_q <= next_ms;
		end
		if (cmd.calc_flags) begin
			sw_start_q <= origin_q;
			sw_end_q   <= wrap ? prev_scan_q : scan_q;
		end
	end

	// running state across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ramp_q       <= '0;
			prev_ramp_valid_q <= 1'b0;
			prev_scan_q       <= '0;
			prev_scan_valid_q <= 1'b0;
			origin_q          <= ORIGIN_RST;
			hit_cnt_q         <= '0;
			has_sweep_q       <= 1'b0;
		end else begin
			if (cmd.calc_scan) begin
				if (!rose) hit_cnt_q <= '0;
				else if (too_many) hit_cnt_q <= HIT_CNT_W'(MAX_HITS);
				else hit_cnt_q <= ms_diff[HIT_CNT_W-1:0];
			end else if (cmd.emit && cmd.sel == KIND_HIT) begin
				hit_cnt_q <= hit_cnt_q - HIT_CNT_W'(1);
			end
			if (cmd.calc_flags) begin
				has_sweep_q       <= wrap || eob_sweep;
				prev_ramp_q       <= ramp_q;
				prev_ramp_valid_q <= 1'b1;
				prev_scan_q       <= scan_q;
				prev_scan_valid_q <= 1'b1;
				if (wrap || eob_q) origin_q <= scan_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q      <= cmd.sel;
			scan_out_q  <= '0;
			crossed_q   <= '0;
			start_out_q <= '0;
			end_out_q   <= '0;
			trunc_out_q <= 1'b0;
			last_q      <= 1'b1;
			unique case (cmd.sel)
				KIND_SCAN: begin
					scan_out_q <= scan_q;
					last_q     <= (hit_cnt_q == '0) && !has_sweep_q;
				end
				KIND_HIT: begin
					crossed_q   <= next_ms;
					trunc_out_q <= trunc_q;
					last_q      <= (hit_cnt_q == HIT_CNT_W'(1)) && !has_sweep_q;
				end
				KIND_SWEEP: begin
					start_out_q <= sw_start_q;
					end_out_q   <= sw_end_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign scan_position  = scan_out_q;
	assign crossed_ms     = crossed_q;
	assign sweep_start    = start_out_q;
	assign sweep_end      = end_out_q;
	assign hits_truncated = trunc_out_q;
	assign last           = last_q;

	`RCST_ASSERT(a_hit_cap, hit_cnt_q <= HIT_CNT_W'(MAX_HITS), "hit count above cap")
	`RCST_ASSERT_IMP(a_emit_free, cmd.emit, out_free, "result loaded over a waiting one")
	`RCST_ASSERT_IMP(a_hit_left, cmd.emit && cmd.sel == KIND_HIT, hit_cnt_q != '0,
		"hit emitted with none left")
	`RCST_ASSERT_IMP(a_sweep_last, out_valid_q && kind_q == KIND_SWEEP, last_q,
		"sweep not marked last")

endmodule

/* src/ramp_crossing_sweep_tracker_unit.sv */
// Ramp crossing sweep tracker.
// Input channel in_valid/in_ready carries ramp_ms (signed, 8 fraction bits) and
// end_of_block. Output channel out_valid/out_ready carries one result item at a
// time: kind, scan_position, crossed_ms, sweep_start, sweep_end, hits_truncated
// and last, which marks the final result of an input item.
// cfg_we/cfg_wdata write the lookahead register; write it only
// while the block is idle.
// Each item yields 1 to 10 results: the scan position, up to eight crossing
// hits, and at most one sweep. The first result is loaded into the output
// register after the capture, scan and compare steps; the rest follow one per
// cycle while the receiver takes them. The next item is accepted in the cycle
// after the last result is loaded. The controller's sequence is capture, scan,
// compare and one emit step per result.
// A stalled receiver holds the output register and the controller waits.
// Reset clears the history, sets the sweep origin to -1 ms and the lookahead
// to 9 ms.
`timescale 1ns / 1ps
module ramp_crossing_sweep_tracker_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] ramp_ms,
	input  logic               end_of_block,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic signed [31:0] scan_position,
	output logic signed [23:0] crossed_ms,
	output logic signed [31:0] sweep_start,
	output logic signed [31:0] sweep_end,
	output logic               hits_truncated,
	output logic               last
);
	import rcst_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rcst_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rcst_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.ramp_ms        (ramp_ms),
		.end_of_block   (end_of_block),
		.cmd            (cmd),
		.stat           (stat),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.kind           (kind),
		.scan_position  (scan_position),
		.crossed_ms     (crossed_ms),
		.sweep_start    (sweep_start),
		.sweep_end      (sweep_end),
		.hits_truncated (hits_truncated),
		.last           (last)
	);

endmodule

/* test/tb_ramp_crossing_sweep_tracker_unit.sv */
`timescale 1ns / 1ps
module tb_ramp_crossing_sweep_tracker_unit;
	import rcst_pkg::*;

	typedef struct {
		logic signed [31:0] ramp;
		logic               eob;
	} sample_t;

	typedef struct {
		kind_t              kind;
		logic signed [31:0] scan;
		logic signed [23:0] crossed;
		logic signed [31:0] span_start;
		logic signed [31:0] span_end;
		logic               trunc;
		logic               last;
	} result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [15:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] ramp_ms = '0;
	logic               end_of_block = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         kind;
	logic signed [31:0] scan_position;
	logic signed [23:0] crossed_ms;
	logic signed [31:0] sweep_start;
	logic signed [31:0] sweep_end;
	logic               hits_truncated;
	logic               last;

	sample_t pending_samples[$];
	result_t awaited_results[$];

	logic [15:0]        lookahead_q = LOOKAHEAD_RST;
	logic signed [31:0] prev_ramp_q = '0;
	logic signed [31:0] prev_scan_q = '0;
	logic signed [31:0] sweep_origin_q = ORIGIN_RST;
	logic               history_ok = 1'b0;
	logic signed [31:0] ramp_pos = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int samples_taken = 0;
	int results_seen = 0;
	int hits_due = 0;
	int sweeps_due = 0;
	int truncated_samples = 0;

	ramp_crossing_sweep_tracker_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.ramp_ms       (ramp_ms),
		.end_of_block  (end_of_block),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.scan_position (scan_position),
		.crossed_ms    (crossed_ms),
		.sweep_start   (sweep_start),
		.sweep_end     (sweep_end),
		.hits_truncated(hits_truncated),
		.last          (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic result_t make_result(kind_t k, longint scan, longint crossed,
			longint s0, longint s1, logic trunc);
		result_t r;
		r.kind = k;
		r.scan = 32'(scan);
		r.crossed = 24'(crossed);
		r.span_start = 32'(s0);
		r.span_end = 32'(s1);
		r.trunc = trunc;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void track_sample(logic signed [31:0] ramp, logic eob);
		longint r;
		longint scan;
		longint fl;
		longint fc;
		longint nhits;
		logic trunc;
		result_t batch[$];
		r = ramp;
		scan = r + longint'(lookahead_q);
		if (scan > longint'(SCAN_MAX))
			scan = SCAN_MAX;
		batch.push_back(make_result(KIND_SCAN, scan, 0, 0, 0, 1'b0));
		if (history_ok && r > longint'(prev_ramp_q)) begin
			fl = longint'(prev_ramp_q) >>> 8;
			fc = r >>> 8;
			trunc = (fc - fl) > MAX_HITS;
			nhits = trunc ? MAX_HITS : fc - fl;
			for (longint i = 1; i <= nhits; i++)
				batch.push_back(make_result(KIND_HIT, 0, fl + i, 0, 0, trunc));
			if (nhits > 0)
				hits_due += int'(nhits);
			if (trunc)
				truncated_samples++;
		end
		if (history_ok && scan < longint'(prev_scan_q)) begin
			batch.push_back(make_result(KIND_SWEEP, 0, 0, sweep_origin_q, prev_scan_q, 1'b0));
			sweeps_due++;
			sweep_origin_q = 32'(scan);
		end
		if (eob) begin
			if (longint'(sweep_origin_q) < scan) begin
				batch.push_back(make_result(KIND_SWEEP, 0, 0, sweep_origin_q, scan, 1'b0));
				sweeps_due++;
			end
			sweep_origin_q = 32'(scan);
		end
		prev_ramp_q = ramp;
		prev_scan_q = 32'(scan);
		history_ok = 1'b1;
		batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			awaited_results.push_back(batch[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin : feed
		sample_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
			ramp_ms <= '0;
			end_of_block <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				track_sample(ramp_ms, end_of_block);
				samples_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s = pending_samples.pop_front();
					in_valid <= 1'b1;
					ramp_ms <= s.ramp;
					end_of_block <= s.eob;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					if (mismatches < 10)
						$display("[%0t] unexpected result: kind=%0d scan=%0d crossed=%0d span=%0d..%0d trunc=%0b last=%0b",
							$realtime, kind, scan_position, crossed_ms, sweep_start, sweep_end,
							hits_truncated, last);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (kind !== want.kind || scan_position !== want.scan ||
							crossed_ms !== want.crossed || sweep_start !== want.span_start ||
							sweep_end !== want.span_end || hits_truncated !== want.trunc ||
							last !== want.last) begin
						if (mismatches < 10) begin
							$display("[%0t] mismatch: exp kind=%0d scan=%0d crossed=%0d span=%0d..%0d trunc=%0b last=%0b",
								$realtime, want.kind, want.scan, want.crossed, want.span_start,
								want.span_end, want.trunc, want.last);
							$display("            got kind=%0d scan=%0d crossed=%0d span=%0d..%0d trunc=%0b last=%0b",
								kind, scan_position, crossed_ms, sweep_start, sweep_end,
								hits_truncated, last);
						end
						mismatches++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic add_sample(logic signed [31:0] ramp, logic eob);
		pending_samples.push_back('{ramp, eob});
	endtask

	task automatic drain();
		wait (pending_samples.size() == 0 && !in_valid && awaited_results.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_lookahead(logic [15:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		lookahead_q = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_random(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 6)
				ramp_pos = $urandom;
			else if (pick < 9)
				ramp_pos = 32'sh7FFF_F000 + $urandom_range(4095);
			else if (pick < 20)
				ramp_pos = ramp_pos - $urandom_range(1, 6000);
			else if (pick < 28)
				ramp_pos = ramp_pos + $urandom_range(2048, 3600);
			else
				ramp_pos = ramp_pos + $urandom_range(0, 900);
			add_sample(ramp_pos, $urandom_range(5) == 0);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_sample(32'sd0, 1'b0);
		add_sample(32'sd778, 1'b0);
		add_sample(32'sd778, 1'b0);
		add_sample(32'sd500, 1'b0);
		add_sample(32'sd2548, 1'b0);
		add_sample(32'sd4852, 1'b1);
		add_sample(-32'sd5120, 1'b1);
		add_sample(-32'sd5020, 1'b1);
		add_sample(32'sh7FFF_FFFF, 1'b0);
		add_sample(32'sh7FFF_FF00, 1'b1);
		add_sample(32'sh8000_0000, 1'b0);
		add_sample(32'sh8000_00FF, 1'b0);
		add_sample(32'sh8000_0100, 1'b0);
		add_sample(32'shFFFF_FFFF, 1'b0);
		add_sample(32'sd1, 1'b1);
		add_sample(32'sh7FFF_FFFF, 1'b1);
		add_sample(32'sh7FFF_FFFF, 1'b1);
		add_sample(32'sh8000_0000, 1'b1);

		write_lookahead(16'd0);
		queue_random(60);

		write_lookahead(16'hFFFF);
		send_idle_pct = 83;
		queue_random(60);

		write_lookahead(16'($urandom));
		send_idle_pct = 0;
		recv_stall_pct = 83;
		queue_random(60);

		write_lookahead(16'($urandom));
		send_idle_pct = 35;
		recv_stall_pct = 35;
		queue_random(70);

		drain();
		repeat (20) @(posedge clk);
		$display("Ran %0d samples through 5 lookahead settings and 4 idle mixes.", samples_taken);
		$display("Checked %0d results: %0d hits, %0d sweeps, %0d capped samples.",
			results_seen, hits_due, sweeps_due, truncated_samples);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("PASS ramp_crossing_sweep_tracker_unit");
		else
			$display("FAIL ramp_crossing_sweep_tracker_unit");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL ramp_crossing_sweep_tracker_unit");
		$finish;
	end

endmodule

/* ramp_crossing_sweep_tracker_unit.f */
+incdir+src
src/rcst_pkg.sv
src/rcst_controller.sv
src/rcst_datapath.sv
src/ramp_crossing_sweep_tracker_unit.sv
test/tb_ramp_crossing_sweep_tracker_unit.sv
